// ===== rtl/mxh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mxh_pkg;

    // word and selector widths
    localparam int unsigned WORD_W = 64;
    localparam int unsigned FUNC_W = 2;

    // selector codes: number of words hashed minus one
    localparam logic [FUNC_W-1:0] FUNC_X    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_XY   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_XYZ  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_XYZW = 2'd3;

    // hash constants
    localparam logic [WORD_W-1:0] K1 = 64'd123456789133;
    localparam logic [WORD_W-1:0] K2 = 64'd456789123499;
    localparam logic [WORD_W-1:0] K3 = 64'd789123456817;
    localparam logic [WORD_W-1:0] K4 = 64'd147258369157;
    localparam logic [WORD_W-1:0] K5 = 64'd258369147317;

    // per-round operation flags, chosen from the selector at each round entry
    typedef struct packed {
        logic mul_en;   // multiply by the round constant, else pass the sum
        logic r_en;     // apply the right xorshift
        logic r_alt;    // use the alternate right shift amount
        logic l_en;     // apply the left xorshift
        logic l_alt;    // use the alternate left shift amount
    } t_ctl;

endpackage

`default_nettype wire

// ===== rtl/mxh_round.sv =====
`timescale 1ns / 1ps
`default_nettype none

// one hash round in three stages: add word, partial products, sum and xorshift
module mxh_round #(
    parameter logic [63:0] K      = mxh_pkg::K1,
    parameter int unsigned R_A    = 31,
    parameter int unsigned R_B    = 31,
    parameter int unsigned L_A    = 29,
    parameter int unsigned L_B    = 29,
    parameter int unsigned SIDE_W = 2
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic                        i_valid,
    input  wire logic [mxh_pkg::WORD_W-1:0]  i_s,
    input  wire logic [mxh_pkg::WORD_W-1:0]  i_word,
    input  wire mxh_pkg::t_ctl               i_ctl,
    input  wire logic [SIDE_W-1:0]           i_side,
    output logic                             o_valid,
    output logic [mxh_pkg::WORD_W-1:0]       o_s,
    output logic [SIDE_W-1:0]                o_side
);

    localparam logic [31:0] KL = K[31:0];
    localparam logic [31:0] KH = K[63:32];

    // stage registers
    logic                        r_v1, r_v2, r_v3;
    logic [mxh_pkg::WORD_W-1:0]  r_t1, r_t2;
    mxh_pkg::t_ctl               r_ctl1, r_ctl2;
    logic [SIDE_W-1:0]           r_side1, r_side2, r_side3;
    logic [63:0]                 r_pll;
    logic [31:0]                 r_pmid;
    logic [mxh_pkg::WORD_W-1:0]  r_s3;

    logic [63:0]                 n_pll;
    logic [31:0]                 n_pmid;
    logic [mxh_pkg::WORD_W-1:0]  n_prod;
    logic [mxh_pkg::WORD_W-1:0]  n_mr;
    logic [mxh_pkg::WORD_W-1:0]  n_s3;

    // valid bits travel with the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // partial products of the low 64 bits of the product
    assign n_pll  = 64'(r_t1[31:0]) * 64'(KL);
    assign n_pmid = r_t1[31:0] * KH + r_t1[63:32] * KL;

    // sum of partials, then right and left xorshifts
    always_comb begin
        n_prod = r_pll + {r_pmid, 32'b0};
        n_mr   = r_ctl2.mul_en ? n_prod : r_t2;
        if (r_ctl2.r_en) begin
            n_mr = n_mr ^ (r_ctl2.r_alt ? (n_mr >> R_B) : (n_mr >> R_A));
        end
        n_s3 = n_mr;
        if (r_ctl2.l_en) begin
            n_s3 = n_mr ^ (r_ctl2.l_alt ? (n_mr << L_B) : (n_mr << L_A));
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_t1    <= i_s + i_word;
            r_ctl1  <= i_ctl;
            r_side1 <= i_side;
            r_pll   <= n_pll;
            r_pmid  <= n_pmid;
            r_t2    <= r_t1;
            r_ctl2  <= r_ctl1;
            r_side2 <= r_side1;
            r_s3    <= n_s3;
            r_side3 <= r_side2;
        end
    end

    assign o_valid = r_v3;
    assign o_s     = r_s3;
    assign o_side  = r_side3;

endmodule

`default_nettype wire

// ===== rtl/multiply_xorshift_hash64.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  tdata                               tuser
// s_axis    in   word_x, word_y, word_z, word_w      func
// m_axis    out  digest                              -
//
// one item per cycle sustained while the output is not stalled; four rounds of three
// stages each (add word, 32x32 partial products, sum and xorshift)
// every 64x64 multiply by a constant is split into three 32x32 partials
// reset clears the valid bits only; the payload registers are not reset
// a stall on the output freezes the whole pipeline, nothing lost or repeated
module multiply_xorshift_hash64 (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [255:0] i_s_tdata,   // word_x, word_y, word_z, word_w
    input  wire logic [1:0]   i_s_tuser,   // func
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [63:0]       o_m_tdata    // digest
);

    localparam int unsigned W  = mxh_pkg::WORD_W;
    localparam int unsigned FW = mxh_pkg::FUNC_W;

    logic                  adv;
    logic [FW-1:0]         func_in;
    logic [W-1:0]          x_in, y_in, z_in, w_in;

    logic [W-1:0]          add1, add2, add3, add4;
    mxh_pkg::t_ctl         ctl1, ctl2, ctl3, ctl4;

    logic                  v1, v2, v3, v4;
    logic [W-1:0]          s1, s2, s3, s4;
    logic [FW+3*W-1:0]     side1;
    logic [FW+2*W-1:0]     side2;
    logic [FW+W-1:0]       side3;
    logic [FW-1:0]         side4;
    logic [FW-1:0]         f1, f2, f3;

    // whole pipeline moves unless the output holds an item not yet taken
    assign adv        = !o_m_tvalid || i_m_tready;
    assign o_s_tready = adv;

    assign func_in = i_s_tuser;
    assign x_in    = i_s_tdata[W-1:0];
    assign y_in    = i_s_tdata[2*W-1:W];
    assign z_in    = i_s_tdata[3*W-1:2*W];
    assign w_in    = i_s_tdata[4*W-1:3*W];

    assign f1 = side1[FW-1:0];
    assign f2 = side2[FW-1:0];
    assign f3 = side3[FW-1:0];

    // round 1: seed constant, multiply by K1, right 31, left 21 or 29
    always_comb begin
        ctl1 = '{mul_en: 1'b1, r_en: 1'b1, r_alt: 1'b0, l_en: 1'b1, l_alt: 1'b0};
        case (func_in)
            mxh_pkg::FUNC_X: begin
                add1       = mxh_pkg::K2;
                ctl1.l_alt = 1'b1;
            end
            mxh_pkg::FUNC_XYZW: add1 = mxh_pkg::K5;
            default:            add1 = mxh_pkg::K4;
        endcase
    end

    // round 2: add y, multiply by K2, right 13, left 11; single word only right 13
    always_comb begin
        ctl2 = '{mul_en: 1'b1, r_en: 1'b1, r_alt: 1'b0, l_en: 1'b1, l_alt: 1'b0};
        add2 = side1[FW+W-1:FW];
        case (f1)
            mxh_pkg::FUNC_X: begin
                ctl2.mul_en = 1'b0;
                ctl2.l_en   = 1'b0;
                add2        = '0;
            end
            default: ;
        endcase
    end

    // round 3: add z where used, multiply by K3, right 17 or 13, left 22; single word passes through
    always_comb begin
        ctl3 = '{mul_en: 1'b1, r_en: 1'b1, r_alt: 1'b0, l_en: 1'b1, l_alt: 1'b0};
        add3 = side2[FW+W-1:FW];
        case (f2)
            mxh_pkg::FUNC_X: begin
                ctl3 = '{mul_en: 1'b0, r_en: 1'b0, r_alt: 1'b0, l_en: 1'b0, l_alt: 1'b0};
                add3 = '0;
            end
            mxh_pkg::FUNC_XY:   add3 = '0;
            mxh_pkg::FUNC_XYZW: ctl3.r_alt = 1'b1;
            default: ;
        endcase
    end

    // round 4: four-word form only, add w, multiply by K4, right 19, left 17
    always_comb begin
        if (f3 == mxh_pkg::FUNC_XYZW) begin
            ctl4 = '{mul_en: 1'b1, r_en: 1'b1, r_alt: 1'b0, l_en: 1'b1, l_alt: 1'b0};
            add4 = side3[FW+W-1:FW];
        end else begin
            ctl4 = '{mul_en: 1'b0, r_en: 1'b0, r_alt: 1'b0, l_en: 1'b0, l_alt: 1'b0};
            add4 = '0;
        end
    end

    mxh_round #(
        .K(mxh_pkg::K1), .R_A(31), .R_B(31), .L_A(29), .L_B(21), .SIDE_W(FW + 3 * W)
    ) u_round1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
        .i_valid(i_s_tvalid), .i_s(x_in), .i_word(add1), .i_ctl(ctl1),
        .i_side({w_in, z_in, y_in, func_in}),
        .o_valid(v1), .o_s(s1), .o_side(side1)
    );

    mxh_round #(
        .K(mxh_pkg::K2), .R_A(13), .R_B(13), .L_A(11), .L_B(11), .SIDE_W(FW + 2 * W)
    ) u_round2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
        .i_valid(v1), .i_s(s1), .i_word(add2), .i_ctl(ctl2),
        .i_side({side1[FW+3*W-1:FW+W], f1}),
        .o_valid(v2), .o_s(s2), .o_side(side2)
    );

    mxh_round #(
        .K(mxh_pkg::K3), .R_A(17), .R_B(13), .L_A(22), .L_B(22), .SIDE_W(FW + W)
    ) u_round3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
        .i_valid(v2), .i_s(s2), .i_word(add3), .i_ctl(ctl3),
        .i_side({side2[FW+2*W-1:FW+W], f2}),
        .o_valid(v3), .o_s(s3), .o_side(side3)
    );

    mxh_round #(
        .K(mxh_pkg::K4), .R_A(19), .R_B(19), .L_A(17), .L_B(17), .SIDE_W(FW)
    ) u_round4 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
        .i_valid(v3), .i_s(s3), .i_word(add4), .i_ctl(ctl4),
        .i_side(f3),
        .o_valid(v4), .o_s(s4), .o_side(side4)
    );

    // last stage of round 4 is the output register
    assign o_m_tvalid = v4 && (side4 == side4);
    assign o_m_tdata  = s4;

endmodule

`default_nettype wire

// ===== bench/multiply_xorshift_hash64_tb.sv =====
`timescale 1ns / 1ps

module multiply_xorshift_hash64_tb;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam logic [mxh_pkg::WORD_W-1:0] ALL_ONES = '1;
    localparam logic [mxh_pkg::WORD_W-1:0] TOP_BIT = 64'h8000_0000_0000_0000;

    // expected digests, oldest first, and the hash they come from
    class digest_scoreboard;
        logic [mxh_pkg::WORD_W-1:0] pending[$];
        int unsigned error_count;

        function new();
            error_count = 0;
        endfunction

        function logic [mxh_pkg::WORD_W-1:0] hash_digest(
                logic [mxh_pkg::FUNC_W-1:0] func,
                logic [mxh_pkg::WORD_W-1:0] x,
                logic [mxh_pkg::WORD_W-1:0] y,
                logic [mxh_pkg::WORD_W-1:0] z,
                logic [mxh_pkg::WORD_W-1:0] w);
            logic [mxh_pkg::WORD_W-1:0] s;
            // single word form
            if (func == mxh_pkg::FUNC_X) begin
                s = (x + mxh_pkg::K2) * mxh_pkg::K1;
                s = s ^ (s >> 31);
                s = s ^ (s << 21);
                s = s ^ (s >> 13);
                return s;
            end
            // first two rounds shared by the multi-word forms
            s = (x + ((func == mxh_pkg::FUNC_XYZW) ? mxh_pkg::K5 : mxh_pkg::K4)) * mxh_pkg::K1;
            s = s ^ (s >> 31);
            s = s ^ (s << 29);
            s = (s + y) * mxh_pkg::K2;
            s = s ^ (s >> 13);
            s = s ^ (s << 11);
            if (func == mxh_pkg::FUNC_XYZ || func == mxh_pkg::FUNC_XYZW) begin
                s = s + z;
            end
            s = s * mxh_pkg::K3;
            // closing rounds
            if (func == mxh_pkg::FUNC_XYZW) begin
                s = s ^ (s >> 13);
                s = s ^ (s << 22);
                s = (s + w) * mxh_pkg::K4;
                s = s ^ (s >> 19);
                s = s ^ (s << 17);
            end else begin
                s = s ^ (s >> 17);
                s = s ^ (s << 22);
            end
            return s;
        endfunction

        function void note_item(logic [mxh_pkg::FUNC_W-1:0] func, logic [255:0] tdata);
            pending.push_back(hash_digest(func, tdata[63:0], tdata[127:64],
                                          tdata[191:128], tdata[255:192]));
        endfunction

        function void check_digest(logic [mxh_pkg::WORD_W-1:0] got);
            logic [mxh_pkg::WORD_W-1:0] want;
            if (pending.size() == 0) begin
                $error("digest: no item pending, expected none, actual %h", got);
                error_count++;
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    $error("digest mismatch: expected %h, actual %h", want, got);
                    error_count++;
                end
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [255:0] i_s_tdata;    // word_x, word_y, word_z, word_w
    logic [1:0]   i_s_tuser;    // func
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [63:0]  o_m_tdata;    // digest

    digest_scoreboard sb;
    int unsigned cycle_count;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned hold_request;
    int unsigned hold_left;

    multiply_xorshift_hash64 dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // item monitor on both channels, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_s_tvalid && o_s_tready === 1'b1) begin
                sb.note_item(i_s_tuser, i_s_tdata);
            end
            if (o_m_tvalid === 1'b1 && i_m_tready) begin
                sb.check_digest(o_m_tdata);
            end
        end
    end

    // receiver: random stalls plus a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_request != 0 && hold_left == 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // word picker biased toward edges and wraparound points
    function automatic logic [mxh_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(11))
            0: return '0;
            1: return ALL_ONES;
            2: return 64'($urandom_range(255));
            3: return TOP_BIT;
            4: return 64'd0 - mxh_pkg::K4;
            5: return ALL_ONES - 64'($urandom_range(15));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // offer one item after any idle cycles, and hold it until accepted
    task automatic send_item(input logic [mxh_pkg::FUNC_W-1:0] func,
                             input logic [mxh_pkg::WORD_W-1:0] x,
                             input logic [mxh_pkg::WORD_W-1:0] y,
                             input logic [mxh_pkg::WORD_W-1:0] z,
                             input logic [mxh_pkg::WORD_W-1:0] w);
        // one idle draw per cycle
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata <= {$urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom(), $urandom()};
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= func;
        i_s_tdata <= {w, z, y, x};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
    endtask

    task automatic send_random(input int unsigned count);
        logic [mxh_pkg::FUNC_W-1:0] func;
        for (int unsigned i = 0; i < count; i++) begin
            func = mxh_pkg::FUNC_W'($urandom_range(3));
            send_item(func, pick_word(), pick_word(), pick_word(), pick_word());
        end
    endtask

    initial begin
        sb = new();
        cycle_count = 0;
        tx_idle_pct = 17;
        rx_idle_pct = 49;
        hold_request = 0;
        hold_left = 0;
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= mxh_pkg::FUNC_X;
        i_m_tready <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes for every selector
        send_item(mxh_pkg::FUNC_X, '0, '0, '0, '0);
        send_item(mxh_pkg::FUNC_X, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        send_item(mxh_pkg::FUNC_XY, '0, '0, '0, '0);
        send_item(mxh_pkg::FUNC_XY, ALL_ONES, ALL_ONES, '0, '0);
        send_item(mxh_pkg::FUNC_XYZ, '0, '0, '0, '0);
        send_item(mxh_pkg::FUNC_XYZ, ALL_ONES, ALL_ONES, ALL_ONES, '0);
        send_item(mxh_pkg::FUNC_XYZW, '0, '0, '0, '0);
        send_item(mxh_pkg::FUNC_XYZW, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        send_item(mxh_pkg::FUNC_XYZW, TOP_BIT, TOP_BIT, TOP_BIT, TOP_BIT);
        // first sum wraps to zero
        send_item(mxh_pkg::FUNC_X, 64'd0 - mxh_pkg::K2, '0, '0, '0);
        send_item(mxh_pkg::FUNC_XY, 64'd0 - mxh_pkg::K4, ALL_ONES, '0, '0);
        send_item(mxh_pkg::FUNC_XYZW, 64'd0 - mxh_pkg::K5, '0, ALL_ONES, TOP_BIT);
        // unused words must not matter: same used words, different rest
        send_item(mxh_pkg::FUNC_X, 64'h0123_4567_89ab_cdef, '0, '0, '0);
        send_item(mxh_pkg::FUNC_X, 64'h0123_4567_89ab_cdef, ALL_ONES, ALL_ONES, ALL_ONES);
        send_item(mxh_pkg::FUNC_XY, 64'hfedc_ba98_7654_3210, 64'd5, '0, '0);
        send_item(mxh_pkg::FUNC_XY, 64'hfedc_ba98_7654_3210, 64'd5, ALL_ONES, ALL_ONES);
        send_item(mxh_pkg::FUNC_XYZ, 64'd7, 64'd11, 64'd13, '0);
        send_item(mxh_pkg::FUNC_XYZ, 64'd7, 64'd11, 64'd13, ALL_ONES);
        // random words in each selector
        for (int f = 0; f < 4; f++) begin
            send_item(mxh_pkg::FUNC_W'(f), {$urandom(), $urandom()},
                      {$urandom(), $urandom()}, {$urandom(), $urandom()},
                      {$urandom(), $urandom()});
        end

        // random items, sender idling lightly and receiver heavily, then the reverse
        send_random(130);
        tx_idle_pct = 49;
        rx_idle_pct = 17;
        send_random(130);
        // no idling, with a long receiver hold-off to back up the pipe
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = 80;
        send_random(140);
        i_s_tvalid <= 1'b0;

        // drain and let the pipeline settle
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
